/* rtl/core/cpc_pkg.sv */
// Package for the calibrated potentiometer conditioner.
// Field widths, scaling constants, op and event codes, sequencer states.
// No dependencies.
package cpc_pkg;

    // field widths
    localparam int OP_W    = 2;
    localparam int SMP_W   = 10;
    localparam int EV_W    = 2;
    localparam int LVL_W   = 7;
    localparam int NUM_W   = 2 * SMP_W;
    localparam int CNT_W   = 4;

    // scaling and threshold constants
    localparam logic [SMP_W-1:0] FULL_SCALE  = 10'd1023;
    localparam logic [SMP_W-1:0] CAL_MIDPT   = 10'd511;
    localparam logic [SMP_W:0]   MOVE_STEP   = 11'd8;
    localparam logic [CNT_W-1:0] DIV_LAST    = CNT_W'(SMP_W - 1);

    // op codes of an input request
    localparam logic [OP_W-1:0] OP_READ = 2'd0;
    localparam logic [OP_W-1:0] OP_CAL  = 2'd1;
    localparam logic [OP_W-1:0] OP_LOAD = 2'd2;

    // result event codes
    localparam logic [EV_W-1:0] EV_NONE    = 2'd0;
    localparam logic [EV_W-1:0] EV_CONTROL = 2'd1;
    localparam logic [EV_W-1:0] EV_PRESS   = 2'd2;
    localparam logic [EV_W-1:0] EV_RELEASE = 2'd3;

    // sequencer states, one-hot
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PREP = 5'b00010,
        S_LOAD = 5'b00100,
        S_DIV  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

endpackage

/* rtl/core/calibrated_pot_conditioner.sv */
// Calibrated potentiometer conditioner: rescale, dead band, button events.
// Depends on cpc_pkg; the divide is a one-bit-per-cycle restoring loop.
//
//  channel   dir  handshake                   payload
//  input     in   i_in_valid / o_in_ready     i_op, i_sample, i_load_low, i_load_high
//  output    out  o_out_valid / i_out_ready   o_event_res, o_value, o_low_bound,
//                                             o_high_bound, o_calibrating
//  config    in   i_cfg_valid / o_cfg_ready   i_cfg_data (button_mode)
//
// A read request passes through the set-up states S_PREP and S_LOAD, the restoring
// divider (one quotient bit per step, ten bits in all) and the finish state S_FIN;
// the next request is taken in the cycle after the finish. Equal bounds, a sample
// on the lower bound, a negative ratio and clamped reads skip the divider;
// calibrate and load requests go straight to the finish state. One request at a time.
// Reset (i_rst_n low, synchronous) restores the bounds to 0..1023 and resets the
// tracking state. A stalled result holds the finish step; a new request is taken
// as soon as the result sits in the output register.
module calibrated_pot_conditioner (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [cpc_pkg::OP_W-1:0]    i_op,
    input  logic [cpc_pkg::SMP_W-1:0]   i_sample,
    input  logic [cpc_pkg::SMP_W-1:0]   i_load_low,
    input  logic [cpc_pkg::SMP_W-1:0]   i_load_high,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [cpc_pkg::EV_W-1:0]    o_event_res,
    output logic [cpc_pkg::LVL_W-1:0]   o_value,
    output logic [cpc_pkg::SMP_W-1:0]   o_low_bound,
    output logic [cpc_pkg::SMP_W-1:0]   o_high_bound,
    output logic                        o_calibrating,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_data
);
    import cpc_pkg::*;

    // sequencer and configuration
    t_state              r_state, n_state;
    logic                r_button_mode;

    // latched request
    logic [OP_W-1:0]     r_op;
    logic [SMP_W-1:0]    r_sample, r_load_low, r_load_high;

    // divider datapath
    logic [SMP_W-1:0]    r_dmag, n_dmag;
    logic [SMP_W-1:0]    r_den, n_den;
    logic                r_qzero, n_qzero;
    logic [SMP_W-1:0]    r_rem, n_rem;
    logic [SMP_W-1:0]    r_lo, n_lo;
    logic [CNT_W-1:0]    r_cnt, n_cnt;

    // tracking state
    logic [SMP_W-1:0]    r_last, n_last;
    logic [LVL_W-1:0]    r_prior, n_prior;
    logic                r_started, n_started;
    logic [SMP_W-1:0]    r_cal_low, n_cal_low;
    logic [SMP_W-1:0]    r_cal_high, n_cal_high;

    // output register
    logic                r_out_valid;
    logic [EV_W-1:0]     r_event, n_event;
    logic [LVL_W-1:0]    r_value, n_value;

    // combinational helpers
    logic                in_acc, out_free, fin_go;
    logic [SMP_W:0]      d_diff, den_diff;
    logic [NUM_W-1:0]    num;
    logic [SMP_W:0]      trial, trial_sub;
    logic                trial_ge;
    logic [SMP_W:0]      move;
    logic                moved;
    logic [LVL_W-1:0]    level;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !r_out_valid;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign fin_go      = (r_state == S_FIN) && out_free;

    // set-up arithmetic: differences, magnitudes and the scaled numerator
    assign d_diff   = {1'b0, r_sample} - {1'b0, r_cal_low};
    assign den_diff = {1'b0, r_cal_high} - {1'b0, r_cal_low};
    assign num      = {r_dmag, {SMP_W{1'b0}}} - {{SMP_W{1'b0}}, r_dmag};

    // one restoring divide step
    assign trial     = {r_rem, r_lo[SMP_W-1]};
    assign trial_sub = trial - {1'b0, r_den};
    assign trial_ge  = (trial >= {1'b0, r_den});

    // dead band check on the finished quotient
    assign move  = {1'b0, r_last} - {1'b0, r_lo};
    assign moved = ($signed(move) >= $signed(MOVE_STEP))
                || ($signed(move) <= -$signed(MOVE_STEP));
    assign level = r_lo[SMP_W-1:SMP_W-LVL_W];

    // next-state logic
    always_comb begin
        n_state    = r_state;
        n_dmag     = r_dmag;
        n_den      = r_den;
        n_qzero    = r_qzero;
        n_rem      = r_rem;
        n_lo       = r_lo;
        n_cnt      = r_cnt;
        n_last     = r_last;
        n_prior    = r_prior;
        n_started  = r_started;
        n_cal_low  = r_cal_low;
        n_cal_high = r_cal_high;
        n_event    = r_event;
        n_value    = r_value;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_op == OP_READ) ? S_PREP : S_FIN;
                end
            end
            S_PREP: begin
                // magnitudes; a non-positive quotient or a zero divisor clamps to zero
                n_dmag  = d_diff[SMP_W] ? SMP_W'(-d_diff) : d_diff[SMP_W-1:0];
                n_den   = den_diff[SMP_W] ? SMP_W'(-den_diff) : den_diff[SMP_W-1:0];
                n_qzero = (den_diff == '0) || (d_diff == '0)
                       || (d_diff[SMP_W] != den_diff[SMP_W]);
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (r_qzero) begin
                    n_lo    = '0;
                    n_state = S_FIN;
                end else if (num[NUM_W-1:SMP_W] >= r_den) begin
                    // quotient would exceed full scale
                    n_lo    = FULL_SCALE;
                    n_state = S_FIN;
                end else begin
                    n_rem   = num[NUM_W-1:SMP_W];
                    n_lo    = num[SMP_W-1:0];
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                // numerator bits shift out, quotient bits shift in
                n_rem = trial_ge ? trial_sub[SMP_W-1:0] : trial[SMP_W-1:0];
                n_lo  = {r_lo[SMP_W-2:0], trial_ge};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_event = EV_NONE;
                    n_value = '0;
                    case (r_op)
                        OP_READ: begin
                            if (moved) begin
                                n_last = {r_lo[SMP_W-1:3], 3'b000};
                                if (!r_button_mode) begin
                                    n_event = EV_CONTROL;
                                    n_value = level;
                                end else if (level[LVL_W-1] && !r_prior[LVL_W-1]) begin
                                    n_prior = level;
                                    n_event = EV_PRESS;
                                end else if (!level[LVL_W-1] && r_prior[LVL_W-1]) begin
                                    n_prior = level;
                                    n_event = EV_RELEASE;
                                end
                            end
                        end
                        OP_CAL: begin
                            if ((r_sample > CAL_MIDPT) && !r_started) begin
                                n_started  = 1'b1;
                                n_cal_high = r_sample;
                                n_cal_low  = CAL_MIDPT;
                            end else if (r_started && (r_sample > r_cal_high)) begin
                                n_cal_high = r_sample;
                            end else if (r_started && (r_sample < r_cal_low)) begin
                                n_cal_low = r_sample;
                            end
                        end
                        OP_LOAD: begin
                            n_cal_low  = r_load_low;
                            n_cal_high = r_load_high;
                        end
                        default: begin
                            n_event = EV_NONE;
                        end
                    endcase
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control and tracking registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_button_mode <= 1'b0;
            r_out_valid   <= 1'b0;
            r_last        <= '0;
            r_prior       <= LVL_W'(1);
            r_started     <= 1'b0;
            r_cal_low     <= '0;
            r_cal_high    <= FULL_SCALE;
        end else begin
            r_state    <= n_state;
            r_last     <= n_last;
            r_prior    <= n_prior;
            r_started  <= n_started;
            r_cal_low  <= n_cal_low;
            r_cal_high <= n_cal_high;
            if (i_cfg_valid && o_cfg_ready) begin
                r_button_mode <= i_cfg_data;
            end
            if (fin_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op        <= i_op;
            r_sample    <= i_sample;
            r_load_low  <= i_load_low;
            r_load_high <= i_load_high;
        end
        r_dmag  <= n_dmag;
        r_den   <= n_den;
        r_qzero <= n_qzero;
        r_rem   <= n_rem;
        r_lo    <= n_lo;
        r_cnt   <= n_cnt;
        r_event <= n_event;
        r_value <= n_value;
    end

    // outputs; bounds hold while a result waits since the next finish needs it taken
    assign o_out_valid   = r_out_valid;
    assign o_event_res   = r_event;
    assign o_value       = r_value;
    assign o_low_bound   = r_cal_low;
    assign o_high_bound  = r_cal_high;
    assign o_calibrating = r_started;

    // checks
    a_valid_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FIN))
        else $error("result raised outside the finish step");

    a_control_analog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_event == EV_CONTROL) |-> !r_button_mode)
        else $error("control value emitted in button mode");

    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_event != EV_CONTROL) |-> (r_value == '0))
        else $error("value not zero without a control event");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt <= DIV_LAST))
        else $error("divide counter out of range");

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_den))
        else $error("partial remainder not below divisor");

endmodule
